### rtl/core/assert_macros.svh
// Assertion macros shared by the timer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MST_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timer assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timer assertion failed");

`endif

### rtl/core/mst_pkg.sv
// Package: sizes, operation codes, sequencer states and control types of the timer.
`default_nettype none
package mst_pkg;

	localparam int SLOTS       = 16;
	localparam int SLOT_IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int COUNT_W     = $clog2(SLOTS + 1);
	localparam int PERIOD_BITS = 32;
	localparam int ID_W        = 5;
	localparam int OP_W        = 3;

	localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
	localparam logic [OP_W-1:0] OP_PAUSE  = 3'd3;
	localparam logic [OP_W-1:0] OP_RESUME = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

	localparam logic EV_ACK  = 1'b0;
	localparam logic EV_FIRE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMD,
		ST_ADD_SCAN,
		ST_ADD_FIRE,
		ST_TICK_WALK,
		ST_TICK_EMIT
	} state_t;

	// Control from the sequencer to the countdown unit.
	typedef struct packed {
		logic                  load;
		logic                  step;
		logic [SLOT_IDX_W-1:0] idx;
	} ctl_t;

endpackage
`default_nettype wire

### rtl/core/mst_countdown.sv
// Countdown unit: per-slot period and remaining-tick store with one shared decrementer.
`default_nettype none
module mst_countdown (
	input  wire logic                             clk,
	input  wire mst_pkg::ctl_t                    ctl,
	input  wire logic [mst_pkg::PERIOD_BITS-1:0]  period,
	output logic                                  expire
);

	logic [mst_pkg::PERIOD_BITS-1:0] period_q    [mst_pkg::SLOTS];
	logic [mst_pkg::PERIOD_BITS-1:0] remaining_q [mst_pkg::SLOTS];
	logic [mst_pkg::PERIOD_BITS-1:0] rem;

	// Read the addressed slot and flag expiry on this tick
	assign rem    = remaining_q[ctl.idx];
	assign expire = (rem <= mst_pkg::PERIOD_BITS'(1));

	// Load on add; reload or decrement on a tick step
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			period_q[ctl.idx]    <= period;
			remaining_q[ctl.idx] <= period;
		end else if (ctl.step) begin
			if (expire) begin
				remaining_q[ctl.idx] <= period_q[ctl.idx];
			end else begin
				remaining_q[ctl.idx] <= rem - mst_pkg::PERIOD_BITS'(1);
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/multi_slot_soft_timer.sv
// Top level: command sequencer and slot flags of the multi-slot timer.
`default_nettype none
// A table of SLOTS timer slots driven by start/busy commands. A word is accepted
// when start is high and busy is low; busy stays high until the command's last
// result word, if any, is out. Result words appear for one cycle each under
// strobe and cannot be held off, so the receiver must take them as they come.
// A tick walks every slot once through a single shared countdown unit, then,
// if any slot fired, walks the fire flags again, one slot per cycle, until the
// last firing slot is reported. An add scans for the lowest free slot, one slot
// per cycle, and with instant_fire set its ack is followed by a fire word. Delete,
// pause, resume and clear answer with a single acknowledge word. Fires within
// a tick come out in slot order; active_count in every word of a command is the
// occupancy after that command. There is no clearing pass after reset.
module multi_slot_soft_timer (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [mst_pkg::OP_W-1:0]          operation,
	input  wire logic                              timer_mode,
	input  wire logic [31:0]                       period_ticks,
	input  wire logic                              instant_fire,
	input  wire logic [mst_pkg::ID_W-1:0]          target_id,
	output logic                                   strobe,
	output logic                                   event_kind,
	output logic                                   ok,
	output logic [mst_pkg::ID_W-1:0]               timer_id,
	output logic [mst_pkg::ID_W-1:0]               active_count,
	output logic                                   last
);

	mst_pkg::state_t                   state_q, state_d;
	logic [mst_pkg::SLOT_IDX_W-1:0]    idx_q, idx_d;
	logic [mst_pkg::SLOTS-1:0]         fire_q, fire_d;
	logic [mst_pkg::SLOTS-1:0]         valid_q, valid_d;
	logic [mst_pkg::SLOTS-1:0]         periodic_q, periodic_d;
	logic [mst_pkg::SLOTS-1:0]         paused_q, paused_d;
	logic [mst_pkg::COUNT_W-1:0]       count_q, count_d;
	logic [mst_pkg::ID_W-1:0]          add_id_q, add_id_d;

	// Latched command word
	logic [mst_pkg::OP_W-1:0]          op_q;
	logic                              mode_q;
	logic [mst_pkg::PERIOD_BITS-1:0]   period_q;
	logic                              first_q;
	logic [mst_pkg::ID_W-1:0]          target_q;

	// Result word
	logic                              strobe_q, emit_d;
	logic                              kind_q, kind_d;
	logic                              ok_q, ok_d;
	logic [mst_pkg::ID_W-1:0]          id_q, id_d;
	logic [mst_pkg::ID_W-1:0]          cnt_q, cnt_d;
	logic                              last_q, last_d;

	mst_pkg::ctl_t                     ctl;
	logic                              expire;
	logic                              accept;
	logic                              idx_end;
	logic [mst_pkg::ID_W-1:0]          idx_id;
	logic                              tgt_range;
	logic [mst_pkg::SLOT_IDX_W-1:0]    tgt_idx;
	logic                              tgt_hit;

	assign busy    = (state_q != mst_pkg::ST_IDLE);
	assign accept  = start && !busy;
	assign idx_end = (idx_q == mst_pkg::SLOT_IDX_W'(mst_pkg::SLOTS - 1));
	assign idx_id  = mst_pkg::ID_W'({1'b0, idx_q} + (mst_pkg::SLOT_IDX_W + 1)'(1));

	// Resolve the target id of delete, pause and resume
	assign tgt_range = (target_q != '0) && (int'(target_q) <= mst_pkg::SLOTS);
	assign tgt_idx   = mst_pkg::SLOT_IDX_W'(target_q - mst_pkg::ID_W'(1));
	assign tgt_hit   = tgt_range && valid_q[tgt_idx];

	mst_countdown u_countdown (
		.clk    (clk),
		.ctl    (ctl),
		.period (period_q),
		.expire (expire)
	);

	// Advance the state register, slot index, slot flags, occupancy count and strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mst_pkg::ST_IDLE;
			idx_q      <= '0;
			fire_q     <= '0;
			valid_q    <= '0;
			periodic_q <= '0;
			paused_q   <= '0;
			count_q    <= '0;
			strobe_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			idx_q      <= idx_d;
			fire_q     <= fire_d;
			valid_q    <= valid_d;
			periodic_q <= periodic_d;
			paused_q   <= paused_d;
			count_q    <= count_d;
			strobe_q   <= emit_d;
		end
	end

	// Hold the command word and the result word
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= operation;
			mode_q   <= timer_mode;
			period_q <= mst_pkg::PERIOD_BITS'(period_ticks);
			first_q  <= instant_fire;
			target_q <= target_id;
		end
		add_id_q <= add_id_d;
		kind_q   <= kind_d;
		ok_q     <= ok_d;
		id_q     <= id_d;
		cnt_q    <= cnt_d;
		last_q   <= last_d;
	end

	// Sequence commands and build result words
	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		fire_d     = fire_q;
		valid_d    = valid_q;
		periodic_d = periodic_q;
		paused_d   = paused_q;
		count_d    = count_q;
		add_id_d   = add_id_q;
		emit_d     = 1'b0;
		kind_d     = kind_q;
		ok_d       = ok_q;
		id_d       = id_q;
		cnt_d      = cnt_q;
		last_d     = last_q;
		ctl.load   = 1'b0;
		ctl.step   = 1'b0;
		ctl.idx    = idx_q;

		unique case (state_q)
			mst_pkg::ST_IDLE: begin
				if (accept) begin
					idx_d  = '0;
					fire_d = '0;
					unique case (operation) inside
						mst_pkg::OP_TICK: state_d = mst_pkg::ST_TICK_WALK;
						mst_pkg::OP_ADD:  state_d = mst_pkg::ST_ADD_SCAN;
						default:          state_d = mst_pkg::ST_CMD;
					endcase
				end
			end

			mst_pkg::ST_CMD: begin
				emit_d = 1'b1;
				kind_d = mst_pkg::EV_ACK;
				id_d   = '0;
				last_d = 1'b1;
				unique case (op_q) inside
					mst_pkg::OP_DELETE: begin
						ok_d = tgt_hit;
						if (tgt_hit) begin
							valid_d[tgt_idx] = 1'b0;
							count_d          = count_q - mst_pkg::COUNT_W'(1);
						end
					end
					mst_pkg::OP_PAUSE, mst_pkg::OP_RESUME: begin
						ok_d = tgt_hit;
						if (tgt_hit && periodic_q[tgt_idx]) begin
							paused_d[tgt_idx] = (op_q == mst_pkg::OP_PAUSE);
						end
					end
					mst_pkg::OP_CLEAR: begin
						ok_d    = 1'b1;
						valid_d = '0;
						count_d = '0;
					end
					default: ok_d = 1'b0;
				endcase
				cnt_d   = mst_pkg::ID_W'(count_d);
				state_d = mst_pkg::ST_IDLE;
			end

			mst_pkg::ST_ADD_SCAN: begin
				ctl.idx = idx_q;
				if (!valid_q[idx_q] || idx_end) begin
					emit_d  = 1'b1;
					kind_d  = mst_pkg::EV_ACK;
					last_d  = !first_q;
					state_d = first_q ? mst_pkg::ST_ADD_FIRE : mst_pkg::ST_IDLE;
					if (!valid_q[idx_q]) begin
						// Take the lowest free slot
						ctl.load           = 1'b1;
						valid_d[idx_q]     = 1'b1;
						periodic_d[idx_q]  = mode_q;
						paused_d[idx_q]    = 1'b0;
						count_d            = count_q + mst_pkg::COUNT_W'(1);
						ok_d               = 1'b1;
						id_d               = idx_id;
						add_id_d           = idx_id;
					end else begin
						// Table full
						ok_d     = 1'b0;
						id_d     = '0;
						add_id_d = '0;
					end
					cnt_d = mst_pkg::ID_W'(count_d);
				end else begin
					idx_d = idx_q + mst_pkg::SLOT_IDX_W'(1);
				end
			end

			mst_pkg::ST_ADD_FIRE: begin
				emit_d  = 1'b1;
				kind_d  = mst_pkg::EV_FIRE;
				ok_d    = 1'b1;
				id_d    = add_id_q;
				cnt_d   = mst_pkg::ID_W'(count_q);
				last_d  = 1'b1;
				state_d = mst_pkg::ST_IDLE;
			end

			mst_pkg::ST_TICK_WALK: begin
				// Count down one slot; flag fires, free expired one-shots
				if (valid_q[idx_q]) begin
					ctl.step = 1'b1;
					if (expire) begin
						if (!periodic_q[idx_q] || !paused_q[idx_q]) begin
							fire_d[idx_q] = 1'b1;
						end
						if (!periodic_q[idx_q]) begin
							valid_d[idx_q] = 1'b0;
							count_d        = count_q - mst_pkg::COUNT_W'(1);
						end
					end
				end
				if (idx_end) begin
					idx_d   = '0;
					state_d = (fire_d == '0) ? mst_pkg::ST_IDLE : mst_pkg::ST_TICK_EMIT;
				end else begin
					idx_d = idx_q + mst_pkg::SLOT_IDX_W'(1);
				end
			end

			mst_pkg::ST_TICK_EMIT: begin
				// Report flagged slots in slot order
				if (fire_q[idx_q]) begin
					fire_d[idx_q] = 1'b0;
					emit_d        = 1'b1;
					kind_d        = mst_pkg::EV_FIRE;
					ok_d          = 1'b1;
					id_d          = idx_id;
					cnt_d         = mst_pkg::ID_W'(count_q);
					last_d        = (fire_d == '0);
					if (fire_d == '0) begin
						state_d = mst_pkg::ST_IDLE;
					end
				end
				idx_d = idx_end ? '0 : idx_q + mst_pkg::SLOT_IDX_W'(1);
			end

			default: state_d = mst_pkg::ST_IDLE;
		endcase
	end

	assign strobe       = strobe_q;
	assign event_kind   = kind_q;
	assign ok           = ok_q;
	assign timer_id     = id_q;
	assign active_count = cnt_q;
	assign last         = last_q;

	// Checks
`include "assert_macros.svh"

	`MST_ASSERT_NEXT(a_accept_busy, accept, busy)
	`MST_ASSERT_IMPL(a_count_matches, 1'b1, $countones(valid_q) == int'(count_q))
	`MST_ASSERT_IMPL(a_idle_word_last, strobe_q && !busy, last_q)
	`MST_ASSERT_NEXT(a_last_ends, strobe_q && last_q, !strobe_q)

endmodule
`default_nettype wire
